// ===== hw/rtl/lcd_word_wrap_writer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the LCD word wrap writer
// Shared property templates for the port level checker.
// ----------------------------------------------------------------------------
`ifndef LCD_WORD_WRAP_WRITER_MACROS_SVH
`define LCD_WORD_WRAP_WRITER_MACROS_SVH

// Same cycle implication, sampled on the rising clock, off during reset
`define LWW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lww check failed");

// Next cycle implication, sampled on the rising clock, off during reset
`define LWW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lww check failed");

`endif

// ===== hw/rtl/lww_pkg.sv =====
// ----------------------------------------------------------------------------
// lww_pkg
// Operation codes, register indexes and display constants of the writer.
// ----------------------------------------------------------------------------
package lww_pkg;

    // input operation codes
    localparam logic [2:0] OP_TEXT     = 3'd0;
    localparam logic [2:0] OP_END      = 3'd1;
    localparam logic [2:0] OP_SET_POS  = 3'd2;
    localparam logic [2:0] OP_CLEAR    = 3'd3;
    localparam logic [2:0] OP_RAW_CHAR = 3'd4;
    localparam logic [2:0] OP_RAW_CMD  = 3'd5;

    // configuration register indexes
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;

    // register reset values
    localparam logic [5:0] LINE_WIDTH_RST = 6'd16;
    localparam logic [2:0] ROW_COUNT_RST  = 3'd2;

    // bus bytes
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;

    // register select values
    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    // saturation limits
    localparam logic [2:0] ROW_LIMIT = 3'd4;
    localparam logic [7:0] COL_LIMIT = 8'd255;

    // DDRAM base address of each display row
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h10;
            2'd3:    base = 8'h50;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

// ===== hw/rtl/lcd_word_wrap_writer.sv =====
// ----------------------------------------------------------------------------
// lcd_word_wrap_writer
// Word wrapping text to character-LCD bus write converter.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one item per beat: text
// character, end of string, set position, clear, raw character or raw
// command. Output channel (o_out_valid / i_out_stall) carries one bus write
// per beat, tagged command or data, with o_last on the final write of an item.
// Configuration (line width, row count) is written through i_cfg_we; the user
// must write it only while the block is idle, which the block does not enforce.
// The block takes one item at a time and holds o_in_stall high until it has
// queued every write of that item. A text character other than space writes
// nothing. A single-write item issues its write from the EXEC state into the
// output register. A flush runs CHECK (wrap test), ADDR on a wrap with an
// address command, DATA for the buffered characters and SPACE for the
// trailing space. The word buffer read port and the single shared adder
// (wrap test, column step, address sum) set one write per cycle while the
// output is not stalled. A stall on the output holds the pending write in
// the output register; the sequencer waits and resumes on the next free cycle.
// Synchronous reset clears the sequencer, counters and output valid; the word
// buffer needs no clearing.
// ----------------------------------------------------------------------------
module lcd_word_wrap_writer #(
    parameter int WORD_MAX = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration port
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_op,
    input  logic [7:0] i_code,
    input  logic [1:0] i_row,
    input  logic [5:0] i_col,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_reg_select,
    output logic [7:0] o_bus_byte,
    output logic       o_last
);

    localparam int LEN_W = $clog2(WORD_MAX + 1);
    localparam int IDX_W = (WORD_MAX > 1) ? $clog2(WORD_MAX) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_ADDR  = 3'd3;
    localparam logic [2:0] S_DATA  = 3'd4;
    localparam logic [2:0] S_SPACE = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [5:0]       r_line_width;
    logic [2:0]       r_row_count;
    logic [2:0]       r_op;
    logic [7:0]       r_code;
    logic [1:0]       r_row;
    logic [5:0]       r_col;
    logic [LEN_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_column, n_column;
    logic [2:0]       r_row_tr, n_row_tr;
    logic [7:0]       r_rd_data;
    logic             r_out_valid;
    logic             r_rs;
    logic [7:0]       r_byte;
    logic             r_last;

    logic [7:0] word_mem [WORD_MAX];

    logic             w_accept;
    logic             w_out_free;
    logic             w_emit;
    logic             w_emit_rs;
    logic [7:0]       w_emit_byte;
    logic             w_emit_last;
    logic             w_buf_we;
    logic [7:0]       w_add_a;
    logic [7:0]       w_add_b;
    logic [8:0]       w_sum;
    logic [7:0]       w_col_inc;
    logic             w_wrap;
    logic [2:0]       w_row_step;
    logic             w_addr_cmd;
    logic [LEN_W-1:0] w_idx_inc;
    logic             w_word_done;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // shared adder: wrap test, address sum or column step
    always_comb begin
        w_add_a = r_column;
        w_add_b = 8'd1;
        if (r_state == S_CHECK) begin
            w_add_b = {{(8 - LEN_W){1'b0}}, r_len};
        end else if (r_state == S_EXEC && r_op == lww_pkg::OP_SET_POS) begin
            w_add_a = lww_pkg::row_base(r_row);
            w_add_b = {2'b00, r_col};
        end
    end
    assign w_sum     = {1'b0, w_add_a} + {1'b0, w_add_b};
    assign w_col_inc = (r_column == lww_pkg::COL_LIMIT) ? r_column : w_sum[7:0];
    assign w_wrap    = (w_sum > {3'b000, r_line_width});

    // row tracker step on a wrap and whether that row gets an address command
    assign w_row_step = (r_row_tr < lww_pkg::ROW_LIMIT) ? (r_row_tr + 3'd1) : r_row_tr;
    assign w_addr_cmd = (w_row_step >= 3'd1) && (w_row_step <= 3'd3)
                        && (w_row_step < r_row_count);

    assign w_idx_inc   = LEN_W'(r_idx) + LEN_W'(1);
    assign w_word_done = (w_idx_inc == r_len);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_column    = r_column;
        n_row_tr    = r_row_tr;
        w_emit      = 1'b0;
        w_emit_rs   = lww_pkg::RS_CMD;
        w_emit_byte = r_code;
        w_emit_last = 1'b1;
        w_buf_we    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    lww_pkg::OP_TEXT: begin
                        if (r_code != lww_pkg::SPACE_CHAR) begin
                            if (r_len < LEN_W'(WORD_MAX)) begin
                                w_buf_we = 1'b1;
                                n_len    = r_len + LEN_W'(1);
                            end
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                    lww_pkg::OP_END: begin
                        n_state = (r_len != '0) ? S_CHECK : S_IDLE;
                    end
                    lww_pkg::OP_SET_POS: begin
                        if ({1'b0, r_row} < r_row_count) begin
                            if (w_out_free) begin
                                w_emit      = 1'b1;
                                w_emit_byte = lww_pkg::CMD_SET_ADDR | w_sum[7:0];
                                n_column    = {2'b00, r_col};
                                n_state     = S_IDLE;
                            end
                        end else begin
                            n_column = {2'b00, r_col};
                            n_state  = S_IDLE;
                        end
                    end
                    lww_pkg::OP_CLEAR: begin
                        if (w_out_free) begin
                            w_emit      = 1'b1;
                            w_emit_byte = lww_pkg::CMD_CLEAR;
                            n_row_tr    = 3'd0;
                            n_state     = S_IDLE;
                        end
                    end
                    lww_pkg::OP_RAW_CHAR: begin
                        if (w_out_free) begin
                            w_emit    = 1'b1;
                            w_emit_rs = lww_pkg::RS_DATA;
                            n_column  = w_col_inc;
                            n_state   = S_IDLE;
                        end
                    end
                    lww_pkg::OP_RAW_CMD: begin
                        if (w_out_free) begin
                            w_emit  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CHECK: begin
                n_idx = '0;
                if (w_wrap) begin
                    n_row_tr = w_row_step;
                    n_column = 8'd0;
                end
                if (w_wrap && w_addr_cmd) begin
                    n_state = S_ADDR;
                end else begin
                    n_state = (r_len != '0) ? S_DATA : S_SPACE;
                end
            end
            S_ADDR: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_byte = lww_pkg::CMD_SET_ADDR | lww_pkg::row_base(r_row_tr[1:0]);
                    w_emit_last = 1'b0;
                    n_state     = (r_len != '0) ? S_DATA : S_SPACE;
                end
            end
            S_DATA: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_rs   = lww_pkg::RS_DATA;
                    w_emit_byte = r_rd_data;
                    w_emit_last = w_word_done && (r_op != lww_pkg::OP_TEXT);
                    n_column    = w_col_inc;
                    if (w_word_done) begin
                        n_len   = '0;
                        n_state = (r_op == lww_pkg::OP_TEXT) ? S_SPACE : S_IDLE;
                    end else begin
                        n_idx = w_idx_inc[IDX_W-1:0];
                    end
                end
            end
            S_SPACE: begin
                if (w_out_free) begin
                    w_emit      = 1'b1;
                    w_emit_rs   = lww_pkg::RS_DATA;
                    w_emit_byte = lww_pkg::SPACE_CHAR;
                    n_column    = w_col_inc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_len        <= '0;
            r_idx        <= '0;
            r_column     <= 8'd0;
            r_row_tr     <= 3'd0;
            r_line_width <= lww_pkg::LINE_WIDTH_RST;
            r_row_count  <= lww_pkg::ROW_COUNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_column <= n_column;
            r_row_tr <= n_row_tr;
            if (i_cfg_we) begin
                if (i_cfg_index == lww_pkg::CFG_LINE_WIDTH) begin
                    r_line_width <= i_cfg_data;
                end else begin
                    r_row_count <= i_cfg_data[2:0];
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the accepted beat and the outgoing write
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_op;
            r_code <= i_code;
            r_row  <= i_row;
            r_col  <= i_col;
        end
        if (w_emit) begin
            r_rs   <= w_emit_rs;
            r_byte <= w_emit_byte;
            r_last <= w_emit_last;
        end
    end

    // word buffer: one write port, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (w_buf_we) begin
            word_mem[r_len[IDX_W-1:0]] <= r_code;
        end
        r_rd_data <= word_mem[n_idx];
    end

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_rs;
    assign o_bus_byte   = r_byte;
    assign o_last       = r_last;

endmodule

// ===== hw/rtl/lww_checker.sv =====
// ----------------------------------------------------------------------------
// lww_checker
// Port level checks of the LCD word wrap writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "lcd_word_wrap_writer_macros.svh"

module lww_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic       i_cfg_index,
    input logic [5:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [2:0] i_op,
    input logic [7:0] i_code,
    input logic [1:0] i_row,
    input logic [5:0] i_col,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_reg_select,
    input logic [7:0] o_bus_byte,
    input logic       o_last
);

    // hold a stalled output beat
    `LWW_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_reg_select) && $stable(o_bus_byte) && $stable(o_last))

    // stall the input right after a beat is taken
    `LWW_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // no write may appear in the cycle right after an acceptance with none pending
    `LWW_ASSERT_NXT(a_no_early_write, i_in_valid && !o_in_stall && !o_out_valid,
        !o_out_valid)

    // while idle, a pending write is the final write of its item
    `LWW_ASSERT_IMP(a_idle_last, o_out_valid && !o_in_stall, o_last)

endmodule

bind lcd_word_wrap_writer lww_checker u_lww_checker (.*);

// ===== verif/lcd_word_wrap_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcd_word_wrap_writer_tb
// Self-checking bench for the word wrapping LCD writer. A queue of text and
// control items feeds a clocked driver, and a clocked monitor compares each
// bus write beat against writes worked out by an in-bench display model.
// Both sides idle at random, the receiver once holds off for a long stretch,
// and the line width and row count change between phases.
// ----------------------------------------------------------------------------
module lcd_word_wrap_writer_tb;

    localparam int WORD_MAX      = 32;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int QUIET_LIMIT   = 3000;

    // opcodes outside the defined set, ignored by the block
    localparam logic [2:0] OP_RESERVED_LO = 3'd6;
    localparam logic [2:0] OP_RESERVED_HI = 3'd7;

    // DDRAM start address per row, row 0 in the low byte
    localparam logic [31:0] ROW_STARTS = 32'h50_10_40_00;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] code;
        logic [1:0] row;
        logic [5:0] col;
    } t_lcd_item;

    typedef struct packed {
        logic       rs;
        logic [7:0] data;
        logic       last;
    } t_bus_write;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = lww_pkg::CFG_LINE_WIDTH;
    logic [5:0] cfg_data  = '0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [2:0] op        = lww_pkg::OP_TEXT;
    logic [7:0] code      = '0;
    logic [1:0] row       = '0;
    logic [5:0] col       = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       reg_select;
    logic [7:0] bus_byte;
    logic       last;

    // display model state
    logic [5:0] width_cfg  = lww_pkg::LINE_WIDTH_RST;
    logic [2:0] rows_cfg   = lww_pkg::ROW_COUNT_RST;
    logic [7:0] held_word [WORD_MAX];
    logic [5:0] held_len   = '0;
    logic [7:0] cursor_col = '0;
    logic [2:0] cursor_row = '0;

    t_lcd_item  text_items[$];
    t_bus_write lcd_writes_due[$];

    int  mismatch_count = 0;
    bit  steady         = 1'b0;
    bit  hold_request   = 1'b0;

    t_lcd_item  next_item;
    int         gap_left = 0;
    int         stall_left = 0;
    int         stall_draw;
    int         quiet_cycles = 0;
    t_bus_write want;

    lcd_word_wrap_writer #(
        .WORD_MAX (WORD_MAX)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_op         (op),
        .i_code       (code),
        .i_row        (row),
        .i_col        (col),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_reg_select (reg_select),
        .o_bus_byte   (bus_byte),
        .o_last       (last)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Display model
    // ------------------------------------------------------------------------

    function automatic void put_write(input logic rs, input logic [7:0] b);
        t_bus_write w;
        w.rs   = rs;
        w.data = b;
        w.last = 1'b0;
        lcd_writes_due.push_back(w);
    endfunction

    // data write: advance the cursor, saturating
    function automatic void put_char(input logic [7:0] c);
        if (cursor_col < lww_pkg::COL_LIMIT)
            cursor_col = cursor_col + 8'd1;
        put_write(lww_pkg::RS_DATA, c);
    endfunction

    // wrap if the held word runs past the line, then write it out
    function automatic void flush_held_word();
        if (int'(held_len) + int'(cursor_col) > int'(width_cfg)) begin
            if (cursor_row < lww_pkg::ROW_LIMIT)
                cursor_row = cursor_row + 3'd1;
            if (cursor_row >= 3'd1 && cursor_row <= 3'd3 && cursor_row < rows_cfg)
                put_write(lww_pkg::RS_CMD,
                          lww_pkg::CMD_SET_ADDR | ROW_STARTS[cursor_row[1:0] * 8 +: 8]);
            cursor_col = '0;
        end
        for (int i = 0; i < int'(held_len); i++)
            put_char(held_word[i[4:0]]);
        held_len = '0;
    endfunction

    // work out the bus writes one item causes and mark the final one
    function automatic void format_item(input t_lcd_item it);
        int         n_before;
        t_bus_write tail;
        logic [7:0] addr;
        n_before = lcd_writes_due.size();
        case (it.op)
            lww_pkg::OP_TEXT: begin
                if (it.code != lww_pkg::SPACE_CHAR) begin
                    if (int'(held_len) < WORD_MAX) begin
                        held_word[held_len[4:0]] = it.code;
                        held_len = held_len + 6'd1;
                    end
                end else begin
                    flush_held_word();
                    put_char(lww_pkg::SPACE_CHAR);
                end
            end
            lww_pkg::OP_END: begin
                if (held_len != '0)
                    flush_held_word();
            end
            lww_pkg::OP_SET_POS: begin
                addr = ROW_STARTS[it.row * 8 +: 8] + {2'b00, it.col};
                if ({1'b0, it.row} < rows_cfg)
                    put_write(lww_pkg::RS_CMD, lww_pkg::CMD_SET_ADDR | addr);
                cursor_col = {2'b00, it.col};
            end
            lww_pkg::OP_CLEAR: begin
                put_write(lww_pkg::RS_CMD, lww_pkg::CMD_CLEAR);
                cursor_row = '0;
            end
            lww_pkg::OP_RAW_CHAR: put_char(it.code);
            lww_pkg::OP_RAW_CMD:  put_write(lww_pkg::RS_CMD, it.code);
            default: ;
        endcase
        if (lcd_writes_due.size() > n_before) begin
            tail = lcd_writes_due.pop_back();
            tail.last = 1'b1;
            lcd_writes_due.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offer queued items, predict on every accepted beat
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else if (!(in_valid && in_stall)) begin
            if (in_valid)
                format_item({op, code, row, col});
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (text_items.size() > 0) begin
                next_item = text_items.pop_front();
                op       <= next_item.op;
                code     <= next_item.code;
                row      <= next_item.row;
                col      <= next_item.col;
                in_valid <= 1'b1;
                gap_left <= steady ? 0 : pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted write beat, drive random stalls
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (lcd_writes_due.size() == 0) begin
                    $error("bus write with none predicted: reg_select %0d bus_byte %02h last %0d",
                           reg_select, bus_byte, last);
                    mismatch_count++;
                end else begin
                    want = lcd_writes_due.pop_front();
                    if (reg_select !== want.rs) begin
                        $error("reg_select: expected %0d, got %0d", want.rs, reg_select);
                        mismatch_count++;
                    end
                    if (bus_byte !== want.data) begin
                        $error("bus_byte: expected %02h, got %02h", want.data, bus_byte);
                        mismatch_count++;
                    end
                    if (last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, last);
                        mismatch_count++;
                    end
                end
            end
            if (hold_request) begin
                out_stall  <= 1'b1;
                stall_left <= HOLD_CYCLES;
            end else if (stall_left > 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (steady) begin
                out_stall <= 1'b0;
            end else begin
                stall_draw = pick_gap();
                out_stall  <= (stall_draw > 0);
                stall_left <= (stall_draw > 0) ? stall_draw - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lcd_word_wrap_writer verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_item(input logic [2:0] o, input logic [7:0] c);
        t_lcd_item it;
        it.op   = o;
        it.code = c;
        it.row  = 2'($urandom_range(0, 3));
        it.col  = 6'($urandom_range(0, 63));
        text_items.push_back(it);
    endtask

    task automatic queue_set_pos(input logic [1:0] r, input logic [5:0] c);
        t_lcd_item it;
        it.op   = lww_pkg::OP_SET_POS;
        it.code = 8'($urandom_range(0, 255));
        it.row  = r;
        it.col  = c;
        text_items.push_back(it);
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == lww_pkg::SPACE_CHAR)
            c = 8'h5F;
        return c;
    endfunction

    // mostly words ended by a space or end of string, plus control items
    task automatic queue_traffic(input int goal);
        int added;
        int pick;
        int len;
        added = 0;
        while (added < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36)
                                                   : $urandom_range(1, 8);
                repeat (len) queue_item(lww_pkg::OP_TEXT, word_char());
                if ($urandom_range(0, 3) == 0)
                    queue_item(lww_pkg::OP_END, word_char());
                else
                    queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
                added += len + 1;
            end else if (pick < 70) begin
                queue_set_pos(2'($urandom_range(0, 3)),
                              ($urandom_range(0, 9) == 0) ? 6'($urandom_range(40, 63))
                                                          : 6'($urandom_range(0, 39)));
                added++;
            end else if (pick < 75) begin
                queue_item(lww_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
                added++;
            end else if (pick < 82) begin
                queue_item(lww_pkg::OP_RAW_CHAR, 8'($urandom_range(0, 255)));
                added++;
            end else if (pick < 88) begin
                queue_item(lww_pkg::OP_RAW_CMD, 8'($urandom_range(0, 255)));
                added++;
            end else if (pick < 92) begin
                queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
                added++;
            end else if (pick < 96) begin
                queue_item(lww_pkg::OP_END, 8'($urandom_range(0, 255)));
                added++;
            end else begin
                queue_item($urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO,
                           8'($urandom_range(0, 255)));
                added++;
            end
        end
    endtask

    // wait for every item and write, then let the block settle
    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (text_items.size() != 0 || in_valid || lcd_writes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [5:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lww_pkg::CFG_LINE_WIDTH)
            width_cfg = value;
        else
            rows_cfg = value[2:0];
    endtask

    task automatic set_display(input logic [5:0] width, input logic [2:0] rows);
        write_reg(lww_pkg::CFG_LINE_WIDTH, width);
        write_reg(lww_pkg::CFG_ROW_COUNT, {3'b000, rows});
        @(negedge clk);
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: code extremes, empty flush, missing row, wrap on space
        queue_item(lww_pkg::OP_TEXT, 8'h41);
        queue_item(lww_pkg::OP_TEXT, 8'hFF);
        queue_item(lww_pkg::OP_TEXT, 8'h00);
        queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
        queue_item(lww_pkg::OP_END, 8'h00);
        queue_item(lww_pkg::OP_TEXT, 8'h7A);
        queue_item(lww_pkg::OP_END, 8'hFF);
        queue_set_pos(2'd1, 6'd39);
        queue_set_pos(2'd3, 6'd63);
        queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
        queue_item(lww_pkg::OP_RAW_CHAR, 8'hA5);
        queue_item(lww_pkg::OP_RAW_CHAR, lww_pkg::SPACE_CHAR);
        queue_item(lww_pkg::OP_RAW_CMD, 8'h00);
        queue_item(lww_pkg::OP_RAW_CMD, 8'hFF);
        queue_item(lww_pkg::OP_CLEAR, 8'h00);
        queue_item(OP_RESERVED_LO, 8'h00);
        queue_item(OP_RESERVED_HI, 8'hFF);
        queue_set_pos(2'd2, 6'd24);
        queue_set_pos(2'd0, 6'd10);
        repeat (7) queue_item(lww_pkg::OP_TEXT, word_char());
        queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
        // word longer than the buffer: drop the overflow characters
        repeat (34) queue_item(lww_pkg::OP_TEXT, word_char());
        queue_item(lww_pkg::OP_TEXT, lww_pkg::SPACE_CHAR);
        drain_and_settle();

        // widest line, all rows
        set_display(6'd40, 3'd4);
        queue_traffic(10);
        drain_and_settle();

        // narrowest line, one row; receiver holds off while items queue up
        set_display(6'd1, 3'd1);
        queue_traffic(10);
        hold_request = 1'b1;
        @(negedge clk);
        hold_request = 1'b0;
        drain_and_settle();

        // random setting, no idling on either side
        set_display(6'($urandom_range(1, 40)), 3'($urandom_range(1, 4)));
        steady = 1'b1;
        queue_traffic(10);
        drain_and_settle();
        steady = 1'b0;

        set_display(6'($urandom_range(1, 40)), 3'($urandom_range(1, 4)));
        queue_traffic(8);
        drain_and_settle();

        if (mismatch_count == 0)
            $display("lcd_word_wrap_writer verification clean");
        else
            $display("lcd_word_wrap_writer verification failed");
        $finish;
    end

endmodule
